/* hw/rtl/hsvl_pkg.sv */
// Shared types, constants and helpers of the HSV to serial LED block.
package hsvl_pkg;

    localparam int unsigned LEVEL_W      = 8;
    localparam int unsigned PIXEL_BITS   = 24;
    localparam int unsigned BIT_IDX_W    = $clog2(PIXEL_BITS);
    localparam int unsigned HUE_REGION_W = 43;
    localparam int unsigned FRAC_SCALE   = 6;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;

    // Hue sextants, named by the colours they sweep between
    typedef enum logic [2:0] {
        RGN_RED_YEL  = 3'd0,
        RGN_YEL_GRN  = 3'd1,
        RGN_GRN_CYN  = 3'd2,
        RGN_CYN_BLU  = 3'd3,
        RGN_BLU_MAG  = 3'd4,
        RGN_MAG_RED  = 3'd5
    } region_t;

    // Colour channel codes on the output side
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_NONE  = 2'd3
    } channel_t;

    typedef logic [LEVEL_W-1:0] level_t;

    // After hue split
    typedef struct packed {
        level_t  sat;
        level_t  val;
        region_t region;
        level_t  frac;
    } split_t;

    // After first product row
    typedef struct packed {
        logic    grey;
        level_t  val;
        region_t region;
        level_t  p;
        level_t  sf;
        level_t  sfn;
    } terms_t;

    typedef struct packed {
        level_t r;
        level_t g;
        level_t b;
    } color_t;

    // Upper byte of an 8x8 product
    function automatic level_t scale8(input level_t a, input level_t b);
        logic [2*LEVEL_W-1:0] prod;
        prod = a * b;
        return prod[2*LEVEL_W-1:LEVEL_W];
    endfunction

endpackage

/* hw/rtl/hsvl_split.sv */
// First pipeline stage: hue region and fraction.
module hsvl_split (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hsvl_pkg::level_t hue,
    input  hsvl_pkg::level_t sat,
    input  hsvl_pkg::level_t val,
    output logic            out_valid,
    input  logic            out_ready,
    output hsvl_pkg::split_t out_data
);
    import hsvl_pkg::*;

    localparam level_t BASE1 = LEVEL_W'(HUE_REGION_W * 1);
    localparam level_t BASE2 = LEVEL_W'(HUE_REGION_W * 2);
    localparam level_t BASE3 = LEVEL_W'(HUE_REGION_W * 3);
    localparam level_t BASE4 = LEVEL_W'(HUE_REGION_W * 4);
    localparam level_t BASE5 = LEVEL_W'(HUE_REGION_W * 5);

    logic    valid_reg;
    split_t  data_reg;
    split_t  data_next;
    region_t region;
    level_t  base;
    level_t  rem;
    logic [LEVEL_W+2:0] frac_wide;

    // Divide hue by the region width with a compare ladder
    always_comb
    begin
        if (hue >= BASE5)
        begin
            region = RGN_MAG_RED;
            base   = BASE5;
        end
        else if (hue >= BASE4)
        begin
            region = RGN_BLU_MAG;
            base   = BASE4;
        end
        else if (hue >= BASE3)
        begin
            region = RGN_CYN_BLU;
            base   = BASE3;
        end
        else if (hue >= BASE2)
        begin
            region = RGN_GRN_CYN;
            base   = BASE2;
        end
        else if (hue >= BASE1)
        begin
            region = RGN_YEL_GRN;
            base   = BASE1;
        end
        else
        begin
            region = RGN_RED_YEL;
            base   = '0;
        end
        rem       = hue - base;
        frac_wide = {3'b000, rem} * (LEVEL_W+3)'(FRAC_SCALE);
        data_next.sat    = sat;
        data_next.val    = val;
        data_next.region = region;
        data_next.frac   = frac_wide[LEVEL_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Hold the payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* hw/rtl/hsvl_terms.sv */
// Second and third pipeline stages: p, q, t products and channel select.
module hsvl_terms (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hsvl_pkg::split_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hsvl_pkg::color_t out_color
);
    import hsvl_pkg::*;

    logic   t_valid_reg;
    terms_t t_reg;
    terms_t t_next;
    logic   t_ready;
    logic   c_valid_reg;
    color_t c_reg;
    color_t c_next;
    level_t q;
    level_t t;

    // First product row: p and the two saturation scalings
    always_comb
    begin
        t_next.grey   = (in_data.sat == '0);
        t_next.val    = in_data.val;
        t_next.region = in_data.region;
        t_next.p      = scale8(in_data.val, FULL_LEVEL - in_data.sat);
        t_next.sf     = scale8(in_data.sat, in_data.frac);
        t_next.sfn    = scale8(in_data.sat, FULL_LEVEL - in_data.frac);
    end

    // Second product row and selection by region
    always_comb
    begin
        q = scale8(t_reg.val, FULL_LEVEL - t_reg.sf);
        t = scale8(t_reg.val, FULL_LEVEL - t_reg.sfn);
        if (t_reg.grey)
            c_next = '{r: t_reg.val, g: t_reg.val, b: t_reg.val};
        else
        begin
            case (t_reg.region)
                RGN_RED_YEL: c_next = '{r: t_reg.val, g: t,         b: t_reg.p};
                RGN_YEL_GRN: c_next = '{r: q,         g: t_reg.val, b: t_reg.p};
                RGN_GRN_CYN: c_next = '{r: t_reg.p,   g: t_reg.val, b: t};
                RGN_CYN_BLU: c_next = '{r: t_reg.p,   g: q,         b: t_reg.val};
                RGN_BLU_MAG: c_next = '{r: t,         g: t_reg.p,   b: t_reg.val};
                default:     c_next = '{r: t_reg.val, g: t_reg.p,   b: q};
            endcase
        end
    end

    assign t_ready   = !c_valid_reg || out_ready;
    assign in_ready  = !t_valid_reg || t_ready;
    assign out_valid = c_valid_reg;
    assign out_color = c_reg;

    // Advance both stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                t_valid_reg <= in_valid;
            if (t_ready)
                c_valid_reg <= t_valid_reg;
        end
    end

    // Hold payloads until each stage transfers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            t_reg <= t_next;
        if (t_ready && t_valid_reg)
            c_reg <= c_next;
    end

endmodule

/* hw/rtl/hsvl_shift.sv */
// Serialiser: shifts the 24 colour bits out, red first, MSB first.
module hsvl_shift (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hsvl_pkg::color_t in_color,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             data_bit,
    output hsvl_pkg::channel_t channel,
    output logic             last_bit
);
    import hsvl_pkg::*;

    localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(PIXEL_BITS - 1);

    logic                    busy_reg;
    logic                    busy_next;
    logic [BIT_IDX_W-1:0]    idx_reg;
    logic [BIT_IDX_W-1:0]    idx_next;
    logic [PIXEL_BITS-1:0]   shift_reg;
    logic [PIXEL_BITS-1:0]   shift_next;
    logic                    at_last;
    logic                    load;

    assign at_last  = (idx_reg == LAST_IDX);
    assign in_ready = !busy_reg || (out_ready && at_last);
    assign load     = in_ready && in_valid;

    // Load a new pixel or advance one bit per transfer
    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            shift_next = in_color;
        end
        else if (busy_reg && out_ready)
        begin
            if (at_last)
                busy_next = 1'b0;
            idx_next   = idx_reg + 1'b1;
            shift_next = {shift_reg[PIXEL_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign out_valid = busy_reg;
    assign data_bit  = shift_reg[PIXEL_BITS-1];
    assign channel   = channel_t'(idx_reg[BIT_IDX_W-1:BIT_IDX_W-2]);
    assign last_bit  = at_last;

endmodule

/* hw/rtl/hsv_pixel_to_led_serial.sv */
// Top level: HSV pixel to RGB conversion and serial LED bit stream.
//
// Input stream: one HSV pixel per transfer on s_axis (hue, saturation and
// brightness packed in tdata). Output stream: one colour bit per transfer on
// m_axis; tdata bit 0 carries the data level, tuser the colour channel
// (0 red, 1 green, 2 blue) and tlast marks the 24th bit of each pixel.
// Bits leave red first, then green, then blue, each channel MSB first.
//
// A pixel runs through three register stages (hue split, first product row,
// second product row with channel select); its first bit is offered on
// m_axis once the serialiser is free and has loaded it. The shift register
// sends one bit per cycle while m_axis_tready is high, and consecutive
// pixels follow back to back: the next is loaded as the last bit of the
// previous one transfers. The conversion stages buffer up to three further
// pixels, so s_axis keeps accepting while earlier bits are still going out.
//
// Reset clears all stage valid bits and the serialiser; no output is offered
// until a pixel arrives. When the receiver holds tready low the current bit
// stays on m_axis and the stages fill up before s_axis_tready falls.
module hsv_pixel_to_led_serial (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] hue, [15:8] saturation, [23:16] brightness
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] data_bit, [7:1] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] channel
    output logic        m_axis_tlast    // last_bit
);
    import hsvl_pkg::*;

    logic     split_valid;
    logic     split_ready;
    split_t   split_data;
    logic     color_valid;
    logic     color_ready;
    color_t   color;
    logic     data_bit;
    channel_t channel;

    hsvl_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .hue       (s_axis_tdata[7:0]),
        .sat       (s_axis_tdata[15:8]),
        .val       (s_axis_tdata[23:16]),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_data  (split_data)
    );

    hsvl_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_data   (split_data),
        .out_valid (color_valid),
        .out_ready (color_ready),
        .out_color (color)
    );

    hsvl_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (color_valid),
        .in_ready  (color_ready),
        .in_color  (color),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .data_bit  (data_bit),
        .channel   (channel),
        .last_bit  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0000000, data_bit};
    assign m_axis_tuser = channel;

endmodule

/* hw/rtl/hsvl_check.sv */
// Port-level checker for the HSV to serial LED block, with its bind.
module hsvl_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import hsvl_pkg::*;

    // Hold a stalled bit steady
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // The final bit of a pixel belongs to the blue channel
    a_last_blue: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == CH_BLUE)
        else $error("last bit outside the blue channel");

    // No unused channel code
    a_chan_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != CH_NONE)
        else $error("invalid channel code");

    // Within a pixel the next bit follows at once, same or next channel
    a_bit_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)
            || m_axis_tuser == ($past(m_axis_tuser) + 2'd1)))
        else $error("gap or jump inside a pixel bit run");

endmodule

bind hsv_pixel_to_led_serial hsvl_check u_hsvl_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
